[rtl/sha5_pkg.sv]
// ----------------------------------------------------------------------------
// sha5_pkg
// Shared types, constants and functions of the SHA-512 family hash engine.
// ----------------------------------------------------------------------------
package sha5_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned HashN   = 8;
  localparam int unsigned HashAw  = 3;
  localparam int unsigned WinN    = 16;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned LenW    = 128;

  // Configuration register indexes.
  localparam logic [1:0] CfgVariant = 2'd0;
  localparam logic [1:0] CfgDigest  = 2'd1;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_FEED,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT,
    ST_OUTW
  } state_e;

  // Position inside the padding sequence of the current request.
  typedef enum logic [2:0] {
    PH_DATA,
    PH_MARK,
    PH_ZERO,
    PH_LO,
    PH_NONE,
    PH_END
  } phase_e;

  // Control of the round datapath.
  typedef struct packed {
    logic              push;
    logic [WordW-1:0]  push_word;
    logic              load;
    logic [WordW-1:0]  load_word;
    logic              round;
    logic [WordW-1:0]  k;
    logic              rot;
  } rnd_ctl_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] big_s0(input logic [WordW-1:0] x);
    big_s0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [WordW-1:0] big_s1(input logic [WordW-1:0] x);
    big_s1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [WordW-1:0] sml_s0(input logic [WordW-1:0] x);
    sml_s0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [WordW-1:0] sml_s1(input logic [WordW-1:0] x);
    sml_s1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  // Initial hash value; the unused variant code falls back to SHA-512.
  function automatic logic [WordW-1:0] iv_const(input logic [1:0] var_sel,
                                                input logic [HashAw-1:0] idx);
    logic [WordW-1:0] r;
    r = '0;
    case (var_sel)
      2'd1: begin
        case (idx)
          3'd0: r = 64'hcbbb9d5dc1059ed8;
          3'd1: r = 64'h629a292a367cd507;
          3'd2: r = 64'h9159015a3070dd17;
          3'd3: r = 64'h152fecd8f70e5939;
          3'd4: r = 64'h67332667ffc00b31;
          3'd5: r = 64'h8eb44a8768581511;
          3'd6: r = 64'hdb0c2e0d64f98fa7;
          default: r = 64'h47b5481dbefa4fa4;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0: r = 64'h22312194fc2bf72c;
          3'd1: r = 64'h9f555fa3c84c64c2;
          3'd2: r = 64'h2393b86b6f53b151;
          3'd3: r = 64'h963877195940eabd;
          3'd4: r = 64'h96283ee2a88effe3;
          3'd5: r = 64'hbe5e1e2553863992;
          3'd6: r = 64'h2b0199fc2c85b8aa;
          default: r = 64'h0eb72ddc81c52ca2;
        endcase
      end
      default: begin
        case (idx)
          3'd0: r = 64'h6a09e667f3bcc908;
          3'd1: r = 64'hbb67ae8584caa73b;
          3'd2: r = 64'h3c6ef372fe94f82b;
          3'd3: r = 64'ha54ff53a5f1d36f1;
          3'd4: r = 64'h510e527fade682d1;
          3'd5: r = 64'h9b05688c2b3e6c1f;
          3'd6: r = 64'h1f83d9abfb41bd6b;
          default: r = 64'h5be0cd19137e2179;
        endcase
      end
    endcase
    return r;
  endfunction

  // Round constants.
  function automatic logic [WordW-1:0] k_const(input logic [6:0] r);
    logic [WordW-1:0] k;
    case (r)
      7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

[rtl/sha5_hram.sv]
// ----------------------------------------------------------------------------
// sha5_hram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sha5_hram #(
  parameter int unsigned Depth = 8,
  parameter int unsigned Width = 64,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sha5_round.sv]
// ----------------------------------------------------------------------------
// sha5_round
// Working variables and message schedule window with the round logic.
// ----------------------------------------------------------------------------
module sha5_round (
  input  logic                         clk_i,
  input  sha5_pkg::rnd_ctl_t           ctl_i,
  output logic [sha5_pkg::WordW-1:0]   v0_o
);
  import sha5_pkg::*;

  logic [WordW-1:0] v_q   [HashN];
  logic [WordW-1:0] v_d   [HashN];
  logic [WordW-1:0] win_q [WinN];
  logic [WordW-1:0] win_d [WinN];
  logic [WordW-1:0] t1, t2, w_new;

  // Round function and schedule expansion.
  always_comb begin
    t1 = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + ctl_i.k + win_q[0];
    t2 = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_new = sml_s1(win_q[14]) + win_q[9] + sml_s0(win_q[1]) + win_q[0];
  end

  // Next values of the working variables and the window.
  always_comb begin
    v_d   = v_q;
    win_d = win_q;
    if (ctl_i.push || ctl_i.round) begin
      for (int i = 0; i < WinN - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[WinN-1] = ctl_i.push ? ctl_i.push_word : w_new;
    end
    if (ctl_i.load) begin
      for (int i = 0; i < HashN - 1; i++) begin
        v_d[i] = v_q[i+1];
      end
      v_d[HashN-1] = ctl_i.load_word;
    end else if (ctl_i.rot) begin
      for (int i = 0; i < HashN - 1; i++) begin
        v_d[i] = v_q[i+1];
      end
      v_d[HashN-1] = v_q[0];
    end else if (ctl_i.round) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    win_q <= win_d;
  end

  assign v0_o = v_q[0];

endmodule

[rtl/sha5_regs.sv]
// ----------------------------------------------------------------------------
// sha5_regs
// Configuration registers: initial value select and digest word count.
// ----------------------------------------------------------------------------
module sha5_regs (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [3:0] cfg_data_i,
  output logic [1:0] variant_o,
  output logic [2:0] last_idx_o
);
  import sha5_pkg::*;

  logic [1:0] variant_q, variant_d;
  logic [3:0] dwords_q, dwords_d;

  assign cfg_ready_o = 1'b1;

  // Register writes; indexes beyond the list are dropped.
  always_comb begin
    variant_d = variant_q;
    dwords_d  = dwords_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgVariant: variant_d = cfg_data_i[1:0];
        CfgDigest:  dwords_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= 2'd0;
      dwords_q  <= 4'd8;
    end else begin
      variant_q <= variant_d;
      dwords_q  <= dwords_d;
    end
  end

  // Index of the final digest word, with the count clamped to one through eight.
  always_comb begin
    if (dwords_q == 4'd0) begin
      last_idx_o = 3'd0;
    end else if (dwords_q > 4'd8) begin
      last_idx_o = 3'd7;
    end else begin
      last_idx_o = 3'(dwords_q - 4'd1);
    end
  end

  assign variant_o = variant_q;

endmodule

[rtl/sha512_family_hash_engine.sv]
// ----------------------------------------------------------------------------
// sha512_family_hash_engine
// SHA-512, SHA-384 and SHA-512/256 hash engine over 64-bit message words.
// ----------------------------------------------------------------------------
// The engine takes one message word per request and works on it before it
// takes the next. The sixteenth word of a block starts the compression: the
// hash value RAM is read into the working variables, the eighty rounds run,
// and the result is added back into the RAM. The first word of a message
// first writes the initial value into the RAM. The last word adds the
// padding words (plus a second block when the length does not fit), and
// then each digest word is read from the RAM and shown until taken.
// ----------------------------------------------------------------------------
module sha512_family_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] msg_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_word_o,
  output logic        digest_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);
  import sha5_pkg::*;

  state_e            state_q, state_d;
  phase_e            ph_q, ph_d;
  logic              in_msg_q, in_msg_d;
  logic [3:0]        fill_q, fill_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [6:0]        rnd_q, rnd_d;
  logic [2:0]        oidx_q, oidx_d;
  logic              out_valid_q, out_valid_d;
  logic              out_last_q, out_last_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [WordW-1:0]  word_q;
  logic [3:0]        bcnt_q;
  logic              last_q;

  logic [1:0]        variant;
  logic [2:0]        last_idx;
  logic              in_acc;
  logic [3:0]        bcnt_c;
  logic [WordW-1:0]  pad_word;
  logic [WordW-1:0]  feed_word;
  phase_e            feed_ph;

  logic              we, re;
  logic [HashAw-1:0] waddr, raddr;
  logic [WordW-1:0]  wdata, rdata, v0;
  rnd_ctl_t          ctl;

  sha5_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .variant_o  (variant),
    .last_idx_o (last_idx)
  );

  sha5_hram #(.Depth(HashN), .Width(WordW)) u_hram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  sha5_round u_round (
    .clk_i(clk_i),
    .ctl_i(ctl),
    .v0_o (v0)
  );

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign digest_word_o = rdata;
  assign digest_last_o = out_last_q;

  // Byte count clamped to eight.
  assign bcnt_c = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;

  // Short last word: keep the valid bytes and place the marker byte after them.
  always_comb begin
    pad_word = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < bcnt_q) begin
        pad_word[63-8*b -: 8] = word_q[63-8*b -: 8];
      end else if (4'(b) == bcnt_q) begin
        pad_word[63-8*b -: 8] = 8'h80;
      end
    end
  end

  // Word pushed in the current feed cycle and the padding phase after it.
  always_comb begin
    feed_word = '0;
    feed_ph   = ph_q;
    case (ph_q)
      PH_DATA: begin
        if (!last_q) begin
          feed_word = word_q;
          feed_ph   = PH_NONE;
        end else if (bcnt_q == 4'd8) begin
          feed_word = word_q;
          feed_ph   = PH_MARK;
        end else begin
          feed_word = pad_word;
          feed_ph   = PH_ZERO;
        end
      end
      PH_MARK: begin
        feed_word = {1'b1, 63'd0};
        feed_ph   = PH_ZERO;
      end
      PH_ZERO: begin
        if (fill_q == 4'd14) begin
          feed_word = len_q[LenW-1:WordW];
          feed_ph   = PH_LO;
        end else begin
          feed_word = '0;
          feed_ph   = PH_ZERO;
        end
      end
      PH_LO: begin
        feed_word = len_q[WordW-1:0];
        feed_ph   = PH_END;
      end
      default: begin
        feed_word = '0;
        feed_ph   = ph_q;
      end
    endcase
  end

  // Sequencer: next state, RAM port and datapath control.
  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    in_msg_d    = in_msg_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    rnd_d       = rnd_q;
    oidx_d      = oidx_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    len_d       = len_q;
    we          = 1'b0;
    waddr       = cnt_q[2:0];
    wdata       = '0;
    re          = 1'b0;
    raddr       = cnt_q[2:0];
    ctl         = '0;
    ctl.load_word = rdata;
    ctl.push_word = feed_word;
    ctl.k       = k_const(rnd_q);

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          len_d  = (in_msg_q ? len_q : '0)
                 + LenW'(last_word_i ? {bcnt_c, 3'd0} : 7'd64);
          ph_d   = PH_DATA;
          cnt_d  = '0;
          if (!in_msg_q) begin
            in_msg_d = 1'b1;
            fill_d   = '0;
            state_d  = ST_INIT;
          end else begin
            state_d  = ST_FEED;
          end
        end
      end
      ST_INIT: begin
        we    = 1'b1;
        wdata = iv_const(variant, cnt_q[2:0]);
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd7) begin
          cnt_d   = '0;
          state_d = ST_FEED;
        end
      end
      ST_FEED: begin
        ctl.push = 1'b1;
        fill_d   = fill_q + 4'd1;
        ph_d     = feed_ph;
        if (fill_q == 4'd15) begin
          cnt_d   = '0;
          state_d = ST_LOAD;
        end else if (feed_ph == PH_NONE) begin
          state_d = ST_IDLE;
        end else if (feed_ph == PH_END) begin
          oidx_d  = '0;
          state_d = ST_OUT;
        end
      end
      ST_LOAD: begin
        re       = (cnt_q != 4'd8);
        ctl.load = (cnt_q != 4'd0);
        cnt_d    = cnt_q + 4'd1;
        if (cnt_q == 4'd8) begin
          rnd_d   = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctl.round = 1'b1;
        rnd_d     = rnd_q + 7'd1;
        if (rnd_q == 7'(Rounds - 1)) begin
          rnd_d   = '0;
          cnt_d   = '0;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        re      = (cnt_q != 4'd8);
        we      = (cnt_q != 4'd0);
        waddr   = 3'(cnt_q - 4'd1);
        wdata   = rdata + v0;
        ctl.rot = (cnt_q != 4'd0);
        cnt_d   = cnt_q + 4'd1;
        if (cnt_q == 4'd8) begin
          cnt_d = '0;
          if (ph_q == PH_NONE) begin
            state_d = ST_IDLE;
          end else if (ph_q == PH_END) begin
            oidx_d  = '0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_FEED;
          end
        end
      end
      ST_OUT: begin
        re          = 1'b1;
        raddr       = oidx_q;
        in_msg_d    = 1'b0;
        fill_d      = '0;
        out_valid_d = 1'b1;
        out_last_d  = (oidx_q == last_idx);
        state_d     = ST_OUTW;
      end
      ST_OUTW: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          oidx_d      = oidx_q + 3'd1;
          state_d     = out_last_q ? ST_IDLE : ST_OUT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_NONE;
      in_msg_q    <= 1'b0;
      fill_q      <= '0;
      cnt_q       <= '0;
      rnd_q       <= '0;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      len_q       <= '0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      in_msg_q    <= in_msg_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      rnd_q       <= rnd_d;
      oidx_q      <= oidx_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      len_q       <= len_d;
    end
  end

  // Captured request payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      word_q <= msg_word_i;
      bcnt_q <= bcnt_c;
      last_q <= last_word_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == ST_OUTW)
    else $error("digest shown outside the output wait state");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |-> rnd_q < 7'(Rounds))
    else $error("round counter out of range");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && out_last_q) |=> (state_q == ST_IDLE && !in_msg_q))
    else $error("engine not idle after the final digest word");

  a_feed_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FEED && fill_q == 4'd15) |=> (state_q == ST_LOAD && fill_q == 4'd0))
    else $error("full block did not start compression");
`endif

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// SHA-512 family hash engine testbench
// Sends messages as 64-bit words under random idling on both channels. A
// built-in hash model works out the digest words of each message, and every
// digest word from the engine is checked against it in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sha5_pkg::*;

  typedef struct {
    logic [63:0] word;
    logic        last;
  } digest_t;

  // One row of the directed table. A row may first change the configuration
  // and may repeat its word; a known first digest word is checked where given.
  typedef struct {
    bit          set_cfg;
    logic [3:0]  var_val;
    logic [3:0]  dig_val;
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        last;
    int          rep;
    bit          has_known;
    logic [63:0] known;
  } row_t;

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] StartHash [3][8] = '{
    '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179},
    '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4},
    '{64'h22312194fc2bf72c, 64'h9f555fa3c84c64c2, 64'h2393b86b6f53b151, 64'h963877195940eabd,
      64'h96283ee2a88effe3, 64'hbe5e1e2553863992, 64'h2b0199fc2c85b8aa, 64'h0eb72ddc81c52ca2}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] msg_word_i;
  logic [3:0]  byte_count_i;
  logic        last_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] digest_word_o;
  logic        digest_last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [3:0]  cfg_data_i;

  // Model state.
  logic [63:0]  hash_state [8];
  logic [63:0]  sched [16];
  logic [3:0]   fill_cnt;
  logic [127:0] msg_bits;
  bit           msg_open;
  logic [1:0]   cfg_variant;
  logic [3:0]   cfg_digest;

  digest_t digest_q [$];
  int      err_cnt;
  int      word_cnt;
  int      msg_cnt;
  int      digest_cnt;
  bit      calm;

  sha512_family_hash_engine i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .msg_word_i   (msg_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digest_word_o(digest_word_o),
    .digest_last_o(digest_last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] ror64(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // Eighty rounds over the sixteen collected words.
  function automatic void compress_block();
    logic [63:0] v [8];
    logic [63:0] w, t1, t2, x2, x15;
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = sched[r];
      end else begin
        x2  = sched[(r - 2) & 15];
        x15 = sched[(r - 15) & 15];
        w = (ror64(x2, 19) ^ ror64(x2, 61) ^ (x2 >> 6)) + sched[(r - 7) & 15]
          + (ror64(x15, 1) ^ ror64(x15, 8) ^ (x15 >> 7)) + sched[r & 15];
        sched[r & 15] = w;
      end
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w;
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endfunction

  function automatic void absorb_word(logic [63:0] w);
    sched[fill_cnt] = w;
    fill_cnt++;
    if (fill_cnt == 4'd0) compress_block();
  endfunction

  // Work out the digest words that one accepted message word causes.
  function automatic void hash_predict(logic [63:0] word, logic [3:0] cnt, logic last);
    int unsigned c, n;
    logic [63:0] mask;
    logic [127:0] bits;
    if (!msg_open) begin
      for (int i = 0; i < 8; i++) hash_state[i] = StartHash[cfg_variant == 2'd3 ? 0 : cfg_variant][i];
      msg_bits = '0;
      fill_cnt = '0;
      msg_open = 1'b1;
    end
    if (!last) begin
      msg_bits += 128'd64;
      absorb_word(word);
      return;
    end
    c = (cnt > 8) ? 8 : cnt;
    msg_bits += 128'(c * 8);
    bits = msg_bits;
    if (c == 8) begin
      absorb_word(word);
      absorb_word(64'h8000000000000000);
    end else begin
      mask = (c == 0) ? '0 : ({64{1'b1}} << (64 - 8 * c));
      absorb_word((word & mask) | (64'h80 << (56 - 8 * c)));
    end
    while (fill_cnt != 4'd14) absorb_word('0);
    absorb_word(bits[127:64]);
    absorb_word(bits[63:0]);
    n = (cfg_digest < 1) ? 1 : ((cfg_digest > 8) ? 8 : cfg_digest);
    for (int k = 0; k < n; k++) digest_q.push_back('{hash_state[k], k + 1 == n});
    msg_open = 1'b0;
    msg_cnt++;
  endfunction

  // Send one message word, with a random gap before it unless calm.
  task automatic send_word(logic [63:0] word, logic [3:0] cnt, logic last);
    if (!calm && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    msg_word_i   <= word;
    byte_count_i <= cnt;
    last_word_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    hash_predict(word, cnt, last);
    word_cnt++;
  endtask

  // Let every expected digest word arrive, then allow the engine to settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write both registers; only called while the engine is idle.
  task automatic configure(logic [3:0] var_val, logic [3:0] dig_val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgVariant;
    cfg_data_i  <= var_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_variant = var_val[1:0];
    cfg_index_i <= CfgDigest;
    cfg_data_i  <= dig_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_digest = dig_val;
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver stalls at random unless calm.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 30);
  end

  // Compare each taken digest word with the oldest expectation.
  always @(posedge clk_i) begin
    digest_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h", digest_word_o);
        err_cnt++;
      end else begin
        e = digest_q.pop_front();
        digest_cnt++;
        if (digest_word_o !== e.word) begin
          $error("digest_word: expected %h, got %h", e.word, digest_word_o);
          err_cnt++;
        end
        if (digest_last_o !== e.last) begin
          $error("digest_last: expected %b, got %b", e.last, digest_last_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    row_t rows [$];
    int   first, len;
    logic [3:0] c;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    msg_word_i = '0;
    byte_count_i = '0;
    last_word_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgVariant;
    cfg_data_i = '0;
    calm = 1'b0;
    err_cnt = 0;
    word_cnt = 0;
    msg_cnt = 0;
    digest_cnt = 0;
    cfg_variant = 2'd0;
    cfg_digest = 4'd8;
    msg_open = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message at reset settings: the known SHA-512 digest of nothing.
    rows.push_back('{0, 0, 0, 64'h0, 4'd0, 1, 1, 1, 64'hcf83e1357eefb8bd});
    // SHA-384, digest count zero, byte count above eight on the last word.
    rows.push_back('{1, 4'd1, 4'd0, {64{1'b1}}, 4'd15, 1, 1, 0, 0});
    // SHA-512/256, digest count fifteen, short word not marked last.
    rows.push_back('{1, 4'd2, 4'd15, 64'h0, 4'd8, 0, 1, 0, 0});
    rows.push_back('{0, 0, 0, {64{1'b1}}, 4'd3, 0, 1, 0, 0});
    rows.push_back('{0, 0, 0, 64'h0123456789abcdef, 4'd7, 1, 1, 0, 0});
    // Unused variant code, fifteen words: length spills into a second block.
    rows.push_back('{1, 4'd7, 4'd1, 64'h5555555555555555, 4'd8, 0, 14, 0, 0});
    rows.push_back('{0, 0, 0, 64'haaaaaaaaaaaaaaaa, 4'd8, 1, 1, 0, 0});
    // SHA-512, digest count eight, sixteen words: a full block, then a short last word.
    rows.push_back('{1, 4'd0, 4'd8, 64'haaaaaaaaaaaaaaaa, 4'd8, 0, 16, 0, 0});
    rows.push_back('{0, 0, 0, 64'h55555555deadbeef, 4'd4, 1, 1, 0, 0});
    rows.push_back('{0, 0, 0, {64{1'b1}}, 4'd1, 1, 1, 0, 0});

    foreach (rows[i]) begin
      if (rows[i].set_cfg) begin
        drain();
        configure(rows[i].var_val, rows[i].dig_val);
      end
      first = digest_q.size();
      for (int j = 0; j < rows[i].rep; j++)
        send_word(rows[i].word, rows[i].cnt, rows[i].last);
      if (rows[i].has_known) digest_q[first].word = rows[i].known;
    end

    // Random messages, settings changed now and then; a middle stretch runs calm.
    for (int m = 0; word_cnt < 85; m++) begin
      calm = (m >= 6 && m < 10);
      if ($urandom_range(0, 2) == 0) begin
        drain();
        configure(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end
      len = $urandom_range(0, 20);
      if ($urandom_range(0, 5) == 0) len = $urandom_range(14, 40);
      for (int j = 0; j < len; j++) begin
        // Occasional noise: a random byte count on a word that is not last.
        c = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
        send_word({$urandom, $urandom}, c, 1'b0);
      end
      send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    for (int t = 0; t < 20000 && digest_q.size() != 0; t++) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d words in %0d messages over all variants and digest counts.",
             word_cnt, msg_cnt);
    $display("Checked %0d digest words; %0d still outstanding.", digest_cnt, digest_q.size());
    if (err_cnt == 0 && digest_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
